FILE: sv/tduf_pkg.sv
// Shared types and constants of the tick-driven UART with FIFOs.
package tduf_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_PERIOD      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RECEIVER_ENABLE = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_MIN      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_MAX      = 4'd3;

   // Register reset values
   localparam logic [7:0] BIT_PERIOD_RESET = 8'd104;
   localparam logic [7:0] SAMPLE_MIN_RESET = 8'd5;
   localparam logic [7:0] SAMPLE_MAX_RESET = 8'd100;

   // Receiver takes the start bit plus eight data bits
   localparam logic [3:0] RX_SAMPLE_COUNT = 4'd9;

   typedef struct packed {
      logic       rx_level;
      logic       push_valid;
      logic [7:0] push_byte;
      logic       pop_request;
   } req_item_type;

   typedef struct packed {
      logic       tx_line;
      logic [7:0] pop_byte;
      logic       pop_valid;
      logic       push_dropped;
      logic       rx_overrun;
      logic       rx_busy;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] bit_period;
      logic       receiver_enable;
      logic [7:0] sample_min;
      logic [7:0] sample_max;
   } cfg_type;

endpackage

FILE: sv/tduf_req_if.sv
// Input item channel: one timer tick with rx level, push and pop requests.
interface tduf_req_if;
   logic       valid;
   logic       ready;
   logic       rx_level;
   logic       push_valid;
   logic [7:0] push_byte;
   logic       pop_request;

   modport source (output valid, rx_level, push_valid, push_byte, pop_request, input ready);
   modport sink   (input valid, rx_level, push_valid, push_byte, pop_request, output ready);
endinterface

FILE: sv/tduf_rsp_if.sv
// Result item channel: line level, popped byte and status flags.
interface tduf_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_line;
   logic [7:0] pop_byte;
   logic       pop_valid;
   logic       push_dropped;
   logic       rx_overrun;
   logic       rx_busy;

   modport source (output valid, tx_line, pop_byte, pop_valid, push_dropped, rx_overrun,
                   rx_busy, input ready);
   modport sink   (input valid, tx_line, pop_byte, pop_valid, push_dropped, rx_overrun,
                   rx_busy, output ready);
endinterface

FILE: sv/tduf_csr_if.sv
// Configuration write channel: register index and write data.
interface tduf_csr_if import tduf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/tick_driven_uart_with_fifos.sv
// Top level of the tick-driven 8N1 UART with transmit and receive FIFOs.
//
// Each input item is one prescaled timer tick carrying the sampled rx level, an
// optional byte to queue for sending and an optional pop of the oldest received
// byte; each item yields exactly one result item with the tx line level, the
// popped byte and status flags. The block sustains one item per clock cycle
// while the result side is ready: the engine advances all UART state for a
// tick as it takes it, and the FIFO heads are prefetched into registers so a
// pop or a transmit load never waits on the memory read. From item accept to
// result, an item passes through the front queue and the result register.
// A two-entry front queue takes items while the engine is stalled
// by the result side, and the result register holds a finished item while the
// next one is accepted. Each FIFO holds FIFO_DEPTH-1 bytes; a push into a full
// FIFO is dropped and flagged, never overwritten. No clearing pass runs after
// reset. Configuration registers (index 0 bit_period, 1 receiver_enable,
// 2 sample_min, 3 sample_max) are always ready; write them only while the
// block is idle. Writes to other indexes are ignored.
module tick_driven_uart_with_fifos import tduf_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   tduf_req_if.sink   req_chan,
   tduf_rsp_if.source rsp_chan,
   tduf_csr_if.sink   csr_chan
);

   req_item_type head_item;
   logic         head_valid;
   logic         head_pop;

   // Front: accept and hold ticks
   tduf_item_queue u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Back: advance timer, shift bits, move bytes through the FIFOs
   tduf_engine #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (head_item),
      .item_valid (head_valid),
      .item_pop   (head_pop),
      .rsp        (rsp_chan),
      .csr        (csr_chan)
   );

endmodule

FILE: sv/tduf_item_queue.sv
// Front end: two-entry queue of input items ahead of the UART engine.
module tduf_item_queue import tduf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tduf_req_if.sink     req,
   output req_item_type head_item,
   output logic         head_valid,
   input  logic         head_pop
);

   req_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic         pop;

   assign req.ready  = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];

   assign push = req.valid && req.ready;
   assign pop  = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots carry no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{rx_level: req.rx_level, push_valid: req.push_valid,
                                 push_byte: req.push_byte, pop_request: req.pop_request};
      end
   end

endmodule

FILE: sv/tduf_byte_fifo.sv
// Byte FIFO with registered head read and write-to-head bypass.
module tduf_byte_fifo #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_data,
   input  logic       pop,
   output logic       empty,
   output logic       full,
   output logic [7:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [7:0]       store [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;
   logic [7:0]       head_ff;

   assign wr_next = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;

   assign empty     = (rd_ptr_ff == wr_ptr_ff);
   assign full      = (wr_next == rd_ptr_ff);
   assign head_data = head_ff;

   assign rd_ptr_in = pop  ? rd_next : rd_ptr_ff;
   assign wr_ptr_in = push ? wr_next : wr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   // Prefetch the entry the read pointer moves to; take the new byte if it lands there
   always_ff @(posedge clock) begin
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_data;
      end else begin
         head_ff <= store[rd_ptr_in];
      end
   end

endmodule

FILE: sv/tduf_engine.sv
// Back end: bit timer, transmitter, receiver, both FIFOs and the result register.
module tduf_engine import tduf_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type item,
   input  logic         item_valid,
   output logic         item_pop,
   tduf_rsp_if.source   rsp,
   tduf_csr_if.sink     csr
);

   cfg_type      cfg_ff, cfg_in;
   logic [7:0]   timer_ff, timer_in;
   logic [9:0]   tx_shift_ff, tx_shift_in;
   logic         tx_level_ff, tx_level_in;
   logic [7:0]   rx_shift_ff, rx_shift_in;
   logic [3:0]   rx_bits_ff, rx_bits_in;
   logic         rx_active_ff, rx_active_in;
   logic [7:0]   phase_ff, phase_in;
   logic         last_rx_ff, last_rx_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         fire;
   logic         rx_pop, rx_push, rx_empty, rx_full;
   logic [7:0]   rx_head;
   logic         tx_pop, tx_push, tx_empty, tx_full;
   logic [7:0]   tx_head;
   logic         overrun, dropped;
   logic         wrap;
   logic [7:0]   half;
   logic [7:0]   phase_raw, phase_lo;

   // Step when an item waits and the result slot is free or being drained
   assign fire     = item_valid && (!rsp_valid_ff || rsp.ready);
   assign item_pop = fire;

   assign csr.ready = 1'b1;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.tx_line      = rsp_ff.tx_line;
   assign rsp.pop_byte     = rsp_ff.pop_byte;
   assign rsp.pop_valid    = rsp_ff.pop_valid;
   assign rsp.push_dropped = rsp_ff.push_dropped;
   assign rsp.rx_overrun   = rsp_ff.rx_overrun;
   assign rsp.rx_busy      = rsp_ff.rx_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_BIT_PERIOD:      cfg_in.bit_period      = csr.data;
            REG_RECEIVER_ENABLE: cfg_in.receiver_enable = csr.data[0];
            REG_SAMPLE_MIN:      cfg_in.sample_min      = csr.data;
            REG_SAMPLE_MAX:      cfg_in.sample_max      = csr.data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Start-edge phase: half a period away from the timer, within the period, then clamped
   assign half      = {1'b0, cfg_ff.bit_period[7:1]};
   assign phase_raw = (timer_ff > half) ? timer_ff - half : timer_ff + half - 8'd1;
   assign phase_lo  = (phase_raw < cfg_ff.sample_min) ? cfg_ff.sample_min : phase_raw;

   assign wrap = ({1'b0, timer_ff} + 9'd1) >= {1'b0, cfg_ff.bit_period};

   always_comb begin
      timer_in     = timer_ff;
      tx_shift_in  = tx_shift_ff;
      tx_level_in  = tx_level_ff;
      rx_shift_in  = rx_shift_ff;
      rx_bits_in   = rx_bits_ff;
      rx_active_in = rx_active_ff;
      phase_in     = phase_ff;
      last_rx_in   = last_rx_ff;
      rx_pop       = 1'b0;
      rx_push      = 1'b0;
      overrun      = 1'b0;
      tx_pop       = 1'b0;
      tx_push      = 1'b0;
      dropped      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (fire) begin
         rx_pop = item.pop_request && !rx_empty;

         // Sample event at the stored phase
         if (rx_active_ff && (timer_ff == phase_ff)) begin
            if (rx_bits_ff != 4'd0) begin
               rx_shift_in = {item.rx_level, rx_shift_ff[7:1]};
               rx_bits_in  = rx_bits_ff - 4'd1;
            end else begin
               rx_push      = !rx_full || rx_pop;
               overrun      = rx_full && !rx_pop;
               rx_shift_in  = 8'd0;
               rx_active_in = 1'b0;
            end
         end

         // Falling edge while armed and idle
         if (cfg_ff.receiver_enable && !rx_active_ff && last_rx_ff && !item.rx_level) begin
            phase_in     = (phase_lo > cfg_ff.sample_max) ? cfg_ff.sample_max : phase_lo;
            rx_shift_in  = 8'd0;
            rx_bits_in   = RX_SAMPLE_COUNT;
            rx_active_in = 1'b1;
         end
         last_rx_in = item.rx_level;

         // Bit timer and transmitter
         if (wrap) begin
            timer_in = 8'd0;
            if (tx_shift_ff != 10'd0) begin
               tx_level_in = tx_shift_ff[0];
               tx_shift_in = {1'b0, tx_shift_ff[9:1]};
            end else if (!tx_empty) begin
               tx_shift_in = {1'b1, tx_head, 1'b0};
               tx_pop      = 1'b1;
            end
         end else begin
            timer_in = timer_ff + 8'd1;
         end

         // Push lands after the load decision
         if (item.push_valid) begin
            tx_push = !tx_full || tx_pop;
            dropped = tx_full && !tx_pop;
         end

         rsp_in.tx_line      = tx_level_in;
         rsp_in.pop_byte     = rx_pop ? rx_head : 8'd0;
         rsp_in.pop_valid    = rx_pop;
         rsp_in.push_dropped = dropped;
         rsp_in.rx_overrun   = overrun;
         rsp_in.rx_busy      = rx_active_in;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{bit_period: BIT_PERIOD_RESET, receiver_enable: 1'b0,
                           sample_min: SAMPLE_MIN_RESET, sample_max: SAMPLE_MAX_RESET};
         timer_ff     <= 8'd0;
         tx_shift_ff  <= 10'd0;
         tx_level_ff  <= 1'b1;
         rx_shift_ff  <= 8'd0;
         rx_bits_ff   <= 4'd0;
         rx_active_ff <= 1'b0;
         phase_ff     <= 8'd0;
         last_rx_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         timer_ff     <= timer_in;
         tx_shift_ff  <= tx_shift_in;
         tx_level_ff  <= tx_level_in;
         rx_shift_ff  <= rx_shift_in;
         rx_bits_ff   <= rx_bits_in;
         rx_active_ff <= rx_active_in;
         phase_ff     <= phase_in;
         last_rx_ff   <= last_rx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   tduf_byte_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .push_data (item.push_byte),
      .pop       (tx_pop),
      .empty     (tx_empty),
      .full      (tx_full),
      .head_data (tx_head)
   );

   tduf_byte_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (rx_shift_ff),
      .pop       (rx_pop),
      .empty     (rx_empty),
      .full      (rx_full),
      .head_data (rx_head)
   );

endmodule
